### rtl/bps_pkg.sv
// Package: shared types and constants for the bicubic pixel sampler
package bps_pkg;

    localparam int MaxWidth  = 256;
    localparam int MaxHeight = 256;
    localparam int FracBits  = 8;
    localparam int ColBits   = $clog2(MaxWidth);
    localparam int RowBits   = $clog2(MaxHeight);
    localparam int AddrBits  = ColBits + RowBits;
    // working width of the cubic datapath
    localparam int AccBits   = 40;

    localparam logic [1:0] RegWidth  = 2'd0;
    localparam logic [1:0] RegHeight = 2'd1;
    localparam logic [1:0] RegMax    = 2'd2;

    localparam logic ModeWrite = 1'b0;
    localparam logic ModeQuery = 1'b1;

    // classified query handed from front to back
    typedef struct packed {
        logic                border;
        logic [ColBits-1:0]  sx;
        logic [RowBits-1:0]  sy;
        logic [FracBits-1:0] fx;
        logic [FracBits-1:0] fy;
    } t_job;

    // floor(v * f / 2^s) step of one cubic
    function automatic logic signed [AccBits-1:0] mul_frac(
        input logic signed [AccBits-1:0] v,
        input logic [FracBits-1:0]       f,
        input logic                      half
    );
        logic signed [AccBits+FracBits:0] p;
        p = v * $signed({1'b0, f});
        if (half)
            mul_frac = AccBits'(p >>> (FracBits + 1));
        else
            mul_frac = AccBits'(p >>> FracBits);
    endfunction

endpackage

### rtl/bps_if.sv
// Interfaces: valid/ready channels for items, results and register writes
interface bps_in_if;
    logic        valid;
    logic        ready;
    logic        mode;
    logic [7:0]  pixel_col;
    logic [7:0]  pixel_row;
    logic [15:0] pixel_value;
    logic signed [17:0] query_x;
    logic signed [17:0] query_y;
    modport source (output valid, mode, pixel_col, pixel_row, pixel_value, query_x, query_y,
                    input ready);
    modport sink (input valid, mode, pixel_col, pixel_row, pixel_value, query_x, query_y,
                  output ready);
endinterface

interface bps_out_if;
    logic        valid;
    logic        ready;
    logic [23:0] sample_value;
    modport source (output valid, sample_value, input ready);
    modport sink (input valid, sample_value, output ready);
endinterface

interface bps_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [15:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

### rtl/bicubic_pixel_sampler.sv
// Top level: bicubic pixel sampler with configuration registers
// Usage:
//   in_ch carries items: mode 0 stores pixel_value at (pixel_col, pixel_row)
//   and gives no result; mode 1 queries the Catmull-Rom value at the signed
//   Q9.8 position (query_x, query_y) and gives one Q16.8 result on out_ch.
//   Queries within two pixels of an edge give 0.
//   cfg_ch writes image_width (0), image_height (1) and max_value (2); write
//   them only while the block is idle, which the block does not enforce.
// Timing:
//   A query makes sixteen reads from the read port of the pixel store, one
//   per cycle while fetching, interleaved with five cubic evaluations of
//   three steps each on one shared multiplier. A border query skips the
//   fetch and the cubics and goes straight to the result. The front holds
//   one queued query, so a next query is accepted while the back works or
//   the result waits; a pixel write waits until the back is idle.
// Reset: sizes go to 256, max_value to 255; no result is pending. The
//   pixel store is not cleared. A stalled receiver holds the result and
//   stops new queries once the front slot is full.
module bicubic_pixel_sampler (
    input  logic i_clk,
    input  logic i_rst_n,
    bps_in_if.sink    in_ch,
    bps_out_if.source out_ch,
    bps_cfg_if.sink   cfg_ch
);
    logic [8:0]  r_width;
    logic [8:0]  r_height;
    logic [15:0] r_max;
    logic        job_valid;
    bps_pkg::t_job job;
    logic        busy;
    logic        wr_en;
    logic [bps_pkg::AddrBits-1:0] wr_addr;
    logic [15:0] wr_data;

    // configuration registers
    assign cfg_ch.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= 9'd256;
            r_height <= 9'd256;
            r_max    <= 16'd255;
        end else if (cfg_ch.valid) begin
            case (cfg_ch.index)
                bps_pkg::RegWidth:  r_width  <= cfg_ch.data[8:0];
                bps_pkg::RegHeight: r_height <= cfg_ch.data[8:0];
                bps_pkg::RegMax:    r_max    <= cfg_ch.data;
                default: ;
            endcase
        end
    end

    bps_front u_front (
        .i_clk, .i_rst_n, .in_ch,
        .i_width(r_width), .i_height(r_height), .i_busy(busy),
        .o_job_valid(job_valid), .o_job(job),
        .o_wr_en(wr_en), .o_wr_addr(wr_addr), .o_wr_data(wr_data)
    );

    bps_back u_back (
        .i_clk, .i_rst_n,
        .i_job_valid(job_valid), .i_job(job), .o_busy(busy),
        .i_wr_en(wr_en), .i_wr_addr(wr_addr), .i_wr_data(wr_data),
        .i_max(r_max), .out_ch
    );
endmodule

### rtl/bps_front.sv
// Front: accepts items, stores pixels, classifies queries into jobs
module bps_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    bps_in_if.sink              in_ch,
    input  logic [8:0]          i_width,
    input  logic [8:0]          i_height,
    input  logic                i_busy,
    output logic                o_job_valid,
    output bps_pkg::t_job       o_job,
    output logic                o_wr_en,
    output logic [bps_pkg::AddrBits-1:0] o_wr_addr,
    output logic [15:0]         o_wr_data
);
    logic        r_full;
    bps_pkg::t_job r_job;
    logic [8:0]  w_eff;
    logic [8:0]  h_eff;
    logic signed [18:0] qx;
    logic signed [18:0] qy;
    logic signed [18:0] x_hi;
    logic signed [18:0] y_hi;
    bps_pkg::t_job n_job;

    // accept a query whenever the job slot is free; hold a write until the
    // back is idle so an open query reads the store as it stood at accept
    assign in_ch.ready = !r_full && !(i_busy && (in_ch.mode == bps_pkg::ModeWrite));

    // clip sizes to the store
    assign w_eff = (i_width  > 9'(bps_pkg::MaxWidth))  ? 9'(bps_pkg::MaxWidth)  : i_width;
    assign h_eff = (i_height > 9'(bps_pkg::MaxHeight)) ? 9'(bps_pkg::MaxHeight) : i_height;

    // classify the query against the border
    always_comb begin
        qx   = 19'(in_ch.query_x);
        qy   = 19'(in_ch.query_y);
        x_hi = $signed({1'b0, w_eff, 8'd0}) - 19'sd512;
        y_hi = $signed({1'b0, h_eff, 8'd0}) - 19'sd512;
        n_job.border = (qx < 19'sd512) || (qx >= x_hi) || (qy < 19'sd512) || (qy >= y_hi);
        n_job.sx = in_ch.query_x[bps_pkg::FracBits +: bps_pkg::ColBits];
        n_job.sy = in_ch.query_y[bps_pkg::FracBits +: bps_pkg::RowBits];
        n_job.fx = in_ch.query_x[bps_pkg::FracBits-1:0];
        n_job.fy = in_ch.query_y[bps_pkg::FracBits-1:0];
    end

    // pixel writes go straight to the store
    assign o_wr_en   = in_ch.valid && in_ch.ready && (in_ch.mode == bps_pkg::ModeWrite);
    assign o_wr_addr = {in_ch.pixel_row, in_ch.pixel_col};
    assign o_wr_data = in_ch.pixel_value;

    // hold one job until the back takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full <= 1'b0;
        end else if (in_ch.valid && in_ch.ready && (in_ch.mode == bps_pkg::ModeQuery)) begin
            r_full <= 1'b1;
        end else if (r_full && !i_busy) begin
            r_full <= 1'b0;
        end
        if (in_ch.valid && in_ch.ready)
            r_job <= n_job;
    end

    assign o_job_valid = r_full;
    assign o_job       = r_job;
endmodule

### rtl/bps_back.sv
// Back: fetches the 4x4 window and runs the cubics on one shared unit
module bps_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_job_valid,
    input  bps_pkg::t_job       i_job,
    output logic                o_busy,
    input  logic                i_wr_en,
    input  logic [bps_pkg::AddrBits-1:0] i_wr_addr,
    input  logic [15:0]         i_wr_data,
    input  logic [15:0]         i_max,
    bps_out_if.source           out_ch
);
    typedef enum logic [2:0] {S_IDLE, S_FETCH, S_CUBE, S_CLAMP, S_OUT} t_state;
    typedef logic signed [bps_pkg::AccBits-1:0] t_acc;

    logic [15:0] mem [0:(1 << bps_pkg::AddrBits)-1];
    logic [15:0] r_rd;
    t_state      r_state;
    bps_pkg::t_job r_j;
    logic [4:0]  r_fcnt;     // fetch counter, one read a cycle while fetching, held during a cubic
    logic        r_rdv;
    logic [3:0]  r_wpos;
    t_acc        r_p [0:3];
    t_acc        r_col [0:3];
    logic [2:0]  r_ci;       // cubic index, 4 is the row cubic
    logic [1:0]  r_step;
    t_acc        r_h;
    t_acc        r_val;
    logic [23:0] r_out;
    logic [bps_pkg::ColBits-1:0] rc;
    logic [bps_pkg::RowBits-1:0] rr;
    t_acc        a_t, b_t, m_t;
    logic [bps_pkg::FracBits-1:0] f_sel;
    t_acc        top;

    // store port: write from front, read from fetch sequence
    assign rc = r_j.sx + bps_pkg::ColBits'(r_fcnt[3:2]) - bps_pkg::ColBits'(1);
    assign rr = r_j.sy + bps_pkg::RowBits'(r_fcnt[1:0]) - bps_pkg::RowBits'(1);
    always_ff @(posedge i_clk) begin
        if (i_wr_en)
            mem[i_wr_addr] <= i_wr_data;
        r_rd <= mem[{rr, rc}];
    end

    // cubic terms, one multiply step and the clamp limit
    always_comb begin
        a_t = r_p[2] - r_p[0];
        b_t = (r_p[0] <<< 1) - (r_p[1] <<< 2) - r_p[1] + (r_p[2] <<< 2) - r_p[3];
        f_sel = (r_ci == 3'd4) ? r_j.fx : r_j.fy;
        m_t = bps_pkg::mul_frac(r_h, f_sel, r_step == 2'd2);
        top = (i_max == 16'd0) ? t_acc'(0) : t_acc'({i_max - 16'd1, 8'd0});
    end

    // sequence fetch, cubics, clamp and output
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_rdv   <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_job_valid) begin
                        r_j <= i_job;
                        if (i_job.border) begin
                            r_out   <= 24'd0;
                            r_state <= S_OUT;
                        end else begin
                            r_fcnt  <= 5'd0;
                            r_state <= S_FETCH;
                        end
                    end
                end
                S_FETCH: begin
                    if (r_rdv)
                        r_p[r_wpos[1:0]] <= t_acc'({r_rd, 8'd0});
                    // last pixel of a column: hold the counter, start the cubic
                    if (r_rdv && r_wpos[1:0] == 2'd3) begin
                        r_ci    <= {1'b0, r_wpos[3:2]};
                        r_step  <= 2'd0;
                        r_h     <= (r_p[1] - r_p[2]) * 3 + t_acc'({r_rd, 8'd0}) - r_p[0];
                        r_rdv   <= 1'b0;
                        r_state <= S_CUBE;
                    end else begin
                        r_rdv  <= (r_fcnt < 5'd16);
                        r_wpos <= r_fcnt[3:0];
                        if (r_fcnt < 5'd16)
                            r_fcnt <= r_fcnt + 5'd1;
                    end
                end
                S_CUBE: begin
                    case (r_step)
                        2'd0: begin
                            r_h <= b_t + m_t;
                            r_step <= 2'd1;
                        end
                        2'd1: begin
                            r_h <= a_t + m_t;
                            r_step <= 2'd2;
                        end
                        default: begin
                            if (r_ci == 3'd4) begin
                                r_val   <= r_p[1] + m_t;
                                r_state <= S_CLAMP;
                            end else begin
                                r_col[r_ci[1:0]] <= r_p[1] + m_t;
                                if (r_ci == 3'd3) begin
                                    r_p[0] <= r_col[0];
                                    r_p[1] <= r_col[1];
                                    r_p[2] <= r_col[2];
                                    r_p[3] <= r_p[1] + m_t;
                                    r_h <= (r_col[1] - r_col[2]) * 3 + (r_p[1] + m_t)
                                           - r_col[0];
                                    r_ci   <= 3'd4;
                                    r_step <= 2'd0;
                                end else begin
                                    r_state <= S_FETCH;
                                end
                            end
                        end
                    endcase
                end
                S_CLAMP: begin
                    if (r_val < 0)
                        r_out <= 24'd0;
                    else if (r_val > top)
                        r_out <= top[23:0];
                    else
                        r_out <= r_val[23:0];
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (out_ch.ready)
                        r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_busy = (r_state != S_IDLE);
    assign out_ch.valid = (r_state == S_OUT);
    assign out_ch.sample_value = r_out;
endmodule

### tb/sv/tb.sv
// Testbench for the bicubic pixel sampler: directed and random items checked against a predictor
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic i_clk;
    logic i_rst_n;

    bps_in_if  in_ch();
    bps_out_if out_ch();
    bps_cfg_if cfg_ch();

    bicubic_pixel_sampler DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .in_ch(in_ch.sink), .out_ch(out_ch.source), .cfg_ch(cfg_ch.sink)
    );

    // predictor state
    logic [15:0] img_pixels [0:bps_pkg::MaxWidth*bps_pkg::MaxHeight-1];
    bit          img_written [0:bps_pkg::MaxWidth*bps_pkg::MaxHeight-1];
    logic [8:0]  cur_width;
    logic [8:0]  cur_height;
    logic [15:0] cur_max;

    logic [23:0] sample_queue [$];
    int          fail_count = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;

    // clock
    always begin
        i_clk = 1'b1; #2;
        i_clk = 1'b0; #2;
    end

    // floor(v*f / 2^s)
    function automatic longint scale_frac(longint v, longint f, int s);
        return (v * f) >>> s;
    endfunction

    function automatic longint catmull_rom(longint p0, longint p1, longint p2, longint p3,
                                           longint f);
        longint a, b, c, h;
        a = p2 - p0;
        b = 2 * p0 - 5 * p1 + 4 * p2 - p3;
        c = 3 * (p1 - p2) + p3 - p0;
        h = c;
        h = b + scale_frac(h, f, bps_pkg::FracBits);
        h = a + scale_frac(h, f, bps_pkg::FracBits);
        return p1 + scale_frac(h, f, bps_pkg::FracBits + 1);
    endfunction

    function automatic logic [23:0] predict_sample(logic signed [17:0] qx,
                                                   logic signed [17:0] qy);
        longint w, h, x, y, fx, fy, sx, sy, val, top;
        longint col [4];
        longint row [4];
        x = qx;
        y = qy;
        w = (cur_width < bps_pkg::MaxWidth) ? cur_width : bps_pkg::MaxWidth;
        h = (cur_height < bps_pkg::MaxHeight) ? cur_height : bps_pkg::MaxHeight;
        if (x < (2 << bps_pkg::FracBits) || x >= (w - 2) * (1 << bps_pkg::FracBits) ||
            y < (2 << bps_pkg::FracBits) || y >= (h - 2) * (1 << bps_pkg::FracBits))
            return 24'd0;
        sx = x >>> bps_pkg::FracBits;
        sy = y >>> bps_pkg::FracBits;
        fx = x & ((1 << bps_pkg::FracBits) - 1);
        fy = y & ((1 << bps_pkg::FracBits) - 1);
        for (int i = 0; i < 4; i++) begin
            for (int j = 0; j < 4; j++)
                col[j] = longint'(img_pixels[(sy + j - 1) * bps_pkg::MaxWidth + sx + i - 1])
                         << bps_pkg::FracBits;
            row[i] = catmull_rom(col[0], col[1], col[2], col[3], fy);
        end
        val = catmull_rom(row[0], row[1], row[2], row[3], fx);
        top = (cur_max > 0) ? (longint'(cur_max) - 1) << bps_pkg::FracBits : 0;
        if (val < 0) val = 0;
        if (val > top) val = top;
        return val[23:0];
    endfunction

    // true for a border query, or when the 4x4 window of an interior query is fully written
    function automatic bit window_ready(logic signed [17:0] qx, logic signed [17:0] qy);
        longint sx, sy, w, h;
        w = (cur_width < bps_pkg::MaxWidth) ? cur_width : bps_pkg::MaxWidth;
        h = (cur_height < bps_pkg::MaxHeight) ? cur_height : bps_pkg::MaxHeight;
        if (qx < (2 << bps_pkg::FracBits) || qx >= (w - 2) * (1 << bps_pkg::FracBits) ||
            qy < (2 << bps_pkg::FracBits) || qy >= (h - 2) * (1 << bps_pkg::FracBits))
            return 1'b1;
        sx = longint'(qx) >>> bps_pkg::FracBits;
        sy = longint'(qy) >>> bps_pkg::FracBits;
        for (int i = -1; i < 3; i++)
            for (int j = -1; j < 3; j++)
                if (!img_written[(sy + j) * bps_pkg::MaxWidth + sx + i]) return 1'b0;
        return 1'b1;
    endfunction

    // send one item, updating the predictor on acceptance; valid stays up
    // for a following item and drops while idling
    task automatic send_item(logic mode, logic [7:0] c, logic [7:0] r, logic [15:0] v,
                             logic signed [17:0] qx, logic signed [17:0] qy);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.mode        <= mode;
        in_ch.pixel_col   <= c;
        in_ch.pixel_row   <= r;
        in_ch.pixel_value <= v;
        in_ch.query_x     <= qx;
        in_ch.query_y     <= qy;
        do @(posedge i_clk); while (!in_ch.ready);
        if (mode == bps_pkg::ModeWrite) begin
            img_pixels[r * bps_pkg::MaxWidth + c]  = v;
            img_written[r * bps_pkg::MaxWidth + c] = 1'b1;
        end else begin
            sample_queue.push_back(predict_sample(qx, qy));
        end
        @(negedge i_clk);
    endtask

    task automatic write_pixel(int c, int r, int v);
        send_item(bps_pkg::ModeWrite, c[7:0], r[7:0], v[15:0], 18'sd0, 18'sd0);
    endtask

    task automatic query_at(logic signed [17:0] qx, logic signed [17:0] qy);
        send_item(bps_pkg::ModeQuery, 8'($urandom), 8'($urandom), 16'($urandom), qx, qy);
    endtask

    // wait for all results, then drain
    task automatic drain_results();
        int guard;
        guard = 0;
        in_ch.valid <= 1'b0;
        while (sample_queue.size() != 0 && guard < 200000) begin
            @(negedge i_clk);
            guard++;
        end
        repeat (60) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] data);
        drain_results();
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do @(posedge i_clk); while (!cfg_ch.ready);
        case (idx)
            bps_pkg::RegWidth:  cur_width  = data[8:0];
            bps_pkg::RegHeight: cur_height = data[8:0];
            bps_pkg::RegMax:    cur_max    = data;
            default: ;
        endcase
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // result receiver with random stalls
    always @(negedge i_clk) begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // check each accepted result
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (sample_queue.size() == 0) begin
                $display("%0t: unexpected result %h", $time, out_ch.sample_value);
                fail_count++;
            end else begin
                logic [23:0] want;
                want = sample_queue.pop_front();
                if (out_ch.sample_value !== want) begin
                    $display("%0t: sample_value expected %h actual %h",
                             $time, want, out_ch.sample_value);
                    fail_count++;
                end
            end
        end
    end

    // fill a patch of the image with random values
    task automatic fill_patch(int c0, int r0, int cols, int rows, int vmax);
        for (int r = r0; r < r0 + rows; r++)
            for (int c = c0; c < c0 + cols; c++)
                write_pixel(c, r, $urandom_range(vmax));
    endtask

    task automatic test_directed();
        fill_patch(0, 0, 8, 8, 65535);
        // extremes in the store and writes at the far corner
        write_pixel(255, 255, 65535);
        write_pixel(3, 3, 0);
        write_pixel(4, 4, 65535);
        query_at(18'sh200, 18'sh200);
        query_at(18'sh3FF, 18'sh3FF);
        query_at(18'sh380, 18'sh2C0);
        // near the border, negative and far positions
        query_at(18'sh1FF, 18'sh300);
        query_at(18'sh300, 18'sh1FF);
        query_at(-18'sd131072, 18'sh300);
        query_at(18'sd131071, 18'sd131071);
        query_at(18'sh300, -18'sd1);
        query_at(18'sh0FE00, 18'sh300);
    endtask

    task automatic test_config();
        write_reg(bps_pkg::RegMax, 16'd0);
        query_at(18'sh300, 18'sh300);
        write_reg(bps_pkg::RegMax, 16'd65535);
        query_at(18'sh300, 18'sh380);
        query_at(18'sh2A0, 18'sh3FF);
        write_reg(bps_pkg::RegMax, 16'd1);
        query_at(18'sh300, 18'sh300);
        // smallest sizes: only the column/row at 2 is interior
        write_reg(bps_pkg::RegWidth, 16'd5);
        write_reg(bps_pkg::RegHeight, 16'd5);
        write_reg(bps_pkg::RegMax, 16'd65535);
        query_at(18'sh280, 18'sh2F0);
        query_at(18'sh300, 18'sh280);
        // sizes below the minimum and above the store
        write_reg(bps_pkg::RegWidth, 16'd4);
        query_at(18'sh200, 18'sh200);
        write_reg(bps_pkg::RegWidth, 16'h1FF);
        write_reg(bps_pkg::RegHeight, 16'h1FF);
        query_at(18'sh300, 18'sh300);
    endtask

    // random mix: mostly valid queries over a filled region
    task automatic test_random(int n_items, int s_idle, int r_stall);
        int k;
        logic signed [17:0] qx, qy;
        send_idle_pct  = s_idle;
        recv_stall_pct = r_stall;
        k = 0;
        while (k < n_items) begin
            case ($urandom_range(9))
                0, 1: begin
                    write_pixel($urandom_range(255), $urandom_range(255), int'($urandom));
                    k++;
                end
                2: begin
                    qx = 18'($urandom);
                    qy = 18'($urandom);
                    if (window_ready(qx, qy)) begin query_at(qx, qy); k++; end
                end
                default: begin
                    qx = 18'($urandom_range(18'hDFF, 18'h200));
                    qy = 18'($urandom_range(18'hDFF, 18'h200));
                    if (window_ready(qx, qy)) begin query_at(qx, qy); k++; end
                end
            endcase
        end
    endtask

    initial begin
        i_rst_n        = 1'b0;
        in_ch.valid    = 1'b0;
        in_ch.mode     = bps_pkg::ModeWrite;
        in_ch.pixel_col = '0;
        in_ch.pixel_row = '0;
        in_ch.pixel_value = '0;
        in_ch.query_x  = '0;
        in_ch.query_y  = '0;
        out_ch.ready   = 1'b1;
        cfg_ch.valid   = 1'b0;
        cfg_ch.index   = bps_pkg::RegWidth;
        cfg_ch.data    = '0;
        cur_width = 9'd256;
        cur_height = 9'd256;
        cur_max = 16'd255;
        for (int i = 0; i < bps_pkg::MaxWidth * bps_pkg::MaxHeight; i++)
            img_written[i] = 1'b0;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_config();
        // prepare a dense patch so random queries mostly hit written pixels
        write_reg(bps_pkg::RegWidth, 16'd40);
        write_reg(bps_pkg::RegHeight, 16'd36);
        write_reg(bps_pkg::RegMax, 16'd4096);
        fill_patch(0, 0, 16, 16, 4095);
        test_random(140, 0, 0);
        test_random(140, 65, 0);
        write_reg(bps_pkg::RegMax, 16'd65535);
        write_reg(bps_pkg::RegWidth, 16'd256);
        test_random(140, 0, 65);
        test_random(140, 12, 12);
        drain_results();

        if (fail_count == 0 && sample_queue.size() == 0)
            $display("bicubic_pixel_sampler regression: pass");
        else begin
            if (sample_queue.size() != 0)
                $display("%0t: %0d results never arrived", $time, sample_queue.size());
            $display("bicubic_pixel_sampler regression: fail");
        end
        $finish;
    end

    // run limit
    initial begin
        #4000000;
        $display("bicubic_pixel_sampler regression: fail");
        $finish;
    end
endmodule

### files.f
rtl/bps_pkg.sv
rtl/bps_if.sv
rtl/bps_front.sv
rtl/bps_back.sv
rtl/bicubic_pixel_sampler.sv
tb/sv/tb.sv
